// ===== design/gsd_pkg.sv =====
package gsd_pkg;

  localparam int MapDepth  = 256;
  localparam int MapEntryW = 12;

  localparam logic [1:0] CmdCompare = 2'd0;
  localparam logic [1:0] CmdMapWr   = 2'd1;
  localparam logic [1:0] CmdTabWr   = 2'd2;

  localparam logic [7:0]  GapDot   = 8'h2E;
  localparam logic [7:0]  GapDash  = 8'h2D;
  localparam logic [15:0] GapEntry = 16'hFF00;

  typedef struct packed {
    logic [1:0]         command;
    logic [7:0]         first_char;
    logic [7:0]         second_char;
    logic               last_pair;
    logic [4:0]         row_slot;
    logic [4:0]         col_slot;
    logic               row_known;
    logic               col_known;
    logic signed [15:0] entry_value;
  } gsd_in_t;

  typedef struct packed {
    logic [31:0] distance;
    logic [15:0] indel_count;
    logic        unknown_char;
  } gsd_out_t;

  typedef struct packed {
    logic count;
    logic err;
    logic last;
  } gsd_step_t;

  function automatic logic is_gap(input logic [7:0] c);
    return (c == GapDot) || (c == GapDash);
  endfunction

endpackage

// ===== design/gsd_accum.sv =====
module gsd_accum #(
  parameter int SUM_WIDTH = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_valid_i,
  output logic                step_ready_o,
  input  gsd_pkg::gsd_step_t  step_i,
  input  logic [15:0]         entry_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output gsd_pkg::gsd_out_t   out_data_o
);
  import gsd_pkg::*;

  localparam int AddW = ((SUM_WIDTH > 24) ? SUM_WIDTH : 24) + 1;

  logic [SUM_WIDTH-1:0] sum_q, sum_d;
  logic [15:0]          gaps_q, gaps_d;
  logic                 prev_q, prev_d;
  logic                 err_q, err_d;

  logic                 res_v_q;
  logic [SUM_WIDTH-1:0] res_sum_q;
  logic [15:0]          res_gaps_q;
  logic                 res_err_q;

  logic                 out_v_q;
  gsd_out_t             out_q;

  logic                 out_free, res_free, fire;
  logic                 pos, gapv;
  logic [SUM_WIDTH:0]   sum_ext;
  logic [AddW-1:0]      tot, tot_sat;
  logic [63:0]          tot_wide;
  logic [31:0]          dist_cap;

  assign out_free     = !out_v_q || out_ready_i;
  assign res_free     = !res_v_q || out_free;
  assign step_ready_o = res_free;
  assign fire         = step_valid_i && res_free;

  assign pos  = !entry_i[15] && (entry_i != 16'h0000);
  assign gapv = (entry_i == GapEntry);

  // positive entries stay below 2^15
  assign sum_ext = {1'b0, sum_q} + {{(SUM_WIDTH-14){1'b0}}, entry_i[14:0]};

  always_comb begin
    sum_d  = sum_q;
    gaps_d = gaps_q;
    prev_d = prev_q;
    err_d  = err_q || step_i.err;
    if (step_i.count) begin
      prev_d = gapv;
      if (pos) begin
        sum_d = sum_ext[SUM_WIDTH] ? {SUM_WIDTH{1'b1}} : sum_ext[SUM_WIDTH-1:0];
      end
      if (gapv && !prev_q && (gaps_q != 16'hFFFF)) begin
        gaps_d = gaps_q + 16'd1;
      end
    end
  end

  // indels weigh 1.0 each in q8
  assign tot      = AddW'(res_sum_q) + AddW'({res_gaps_q, 8'h00});
  assign tot_sat  = (tot > AddW'({SUM_WIDTH{1'b1}})) ? AddW'({SUM_WIDTH{1'b1}}) : tot;
  assign tot_wide = 64'(tot_sat);
  assign dist_cap = (tot_wide > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : tot_wide[31:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      gaps_q  <= '0;
      prev_q  <= 1'b0;
      err_q   <= 1'b0;
      res_v_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (fire) begin
        if (step_i.last) begin
          sum_q  <= '0;
          gaps_q <= '0;
          prev_q <= 1'b0;
          err_q  <= 1'b0;
        end else begin
          sum_q  <= sum_d;
          gaps_q <= gaps_d;
          prev_q <= prev_d;
          err_q  <= err_d;
        end
      end
      if (res_free) begin
        res_v_q <= fire && step_i.last;
      end
      if (out_free) begin
        out_v_q <= res_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && step_i.last) begin
      res_sum_q  <= sum_d;
      res_gaps_q <= gaps_d;
      res_err_q  <= err_d;
    end
    if (out_free && res_v_q) begin
      out_q.distance     <= dist_cap;
      out_q.indel_count  <= res_gaps_q;
      out_q.unknown_char <= res_err_q;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && step_i.last |=> (sum_q == '0) && (gaps_q == '0) && !prev_q && !err_q)
    else $error("accumulators not cleared after last beat");

  a_gaps_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && !step_i.last |=> gaps_q >= $past(gaps_q))
    else $error("indel count decreased within a sequence");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && !out_ready_i |=> out_v_q && $stable(out_q))
    else $error("output beat changed while stalled");

endmodule

// ===== design/gapped_sequence_distance_top.sv =====
// gapped sequence distance
// in channel: one beat per cycle, while in_ready_o is high, carries a compare pair,
// a symbol map write or a distance table write, selected by command. writes and
// pairs that do not end a sequence produce no output beat; a pair with last_pair set
// produces exactly one. out channel: distance (q24.8, saturating), indel count and
// unknown-character flag. the result of a last pair passes the map read, table read,
// accumulate and output registers once its input beat is accepted.
// throughput: one beat per cycle while in_ready_o is high; the map and table each
// take one access per cycle and accumulation is a read-modify-write of the sums.
// a stalled receiver backs up the pipeline stage by stage; in_ready_o stays high
// while empty stages remain, so up to three last pairs are taken behind a held result.
// reset: accumulators clear and every symbol map entry reads as unknown at once,
// with no clearing pass; table entries are undefined until written.
module gapped_sequence_distance_top #(
  parameter int ALPHABET_SIZE = 32,
  parameter int SUM_WIDTH     = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  gsd_pkg::gsd_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output gsd_pkg::gsd_out_t out_data_o
);
  import gsd_pkg::*;

  localparam int TabDepth = ALPHABET_SIZE * ALPHABET_SIZE;
  localparam int IdxW     = $clog2(TabDepth);

  logic [MapEntryW-1:0] map_mem [MapDepth];
  logic [MapDepth-1:0]  map_vld_q;
  logic [15:0]          tab_mem [TabDepth];

  logic                 in_fire;
  logic                 row_ok, col_ok;
  logic [MapEntryW-1:0] map_wr_entry;

  logic                 s1_v_q;
  gsd_in_t              s1_q;
  logic [MapEntryW-1:0] ma_q, mb_q;
  logic                 mav_q, mbv_q;

  logic                 s1_fire, s1_cmp, both_gap, known, tab_wr_ok;
  logic [4:0]           rd_row, rd_col;
  logic [IdxW-1:0]      rd_idx, wr_idx;
  gsd_step_t            step_d;

  logic                 s2_v_q;
  gsd_step_t            s2_step_q;
  logic [15:0]          td_q;
  logic                 s2_free, step_ready;

  assign in_fire = in_valid_i && in_ready_o;

  assign row_ok = in_data_i.row_known && (int'(in_data_i.row_slot) < ALPHABET_SIZE);
  assign col_ok = in_data_i.col_known && (int'(in_data_i.col_slot) < ALPHABET_SIZE);
  assign map_wr_entry = {row_ok, row_ok ? in_data_i.row_slot : 5'd0,
                         col_ok, col_ok ? in_data_i.col_slot : 5'd0};

  // symbol map, two read ports and one write port
  always_ff @(posedge clk_i) begin
    if (in_fire && (in_data_i.command == CmdMapWr)) begin
      map_mem[in_data_i.first_char] <= map_wr_entry;
    end
    if (in_fire) begin
      ma_q  <= map_mem[in_data_i.first_char];
      mb_q  <= map_mem[in_data_i.second_char];
      mav_q <= map_vld_q[in_data_i.first_char];
      mbv_q <= map_vld_q[in_data_i.second_char];
      s1_q  <= in_data_i;
    end
  end

  assign s1_cmp    = (s1_q.command == CmdCompare);
  assign both_gap  = is_gap(s1_q.first_char) && is_gap(s1_q.second_char);
  assign known     = mav_q && ma_q[11] && mbv_q && mb_q[5];
  assign rd_row    = ma_q[10:6];
  assign rd_col    = mb_q[4:0];
  assign rd_idx    = IdxW'(int'(rd_row) * ALPHABET_SIZE + int'(rd_col));
  assign wr_idx    = IdxW'(int'(s1_q.row_slot) * ALPHABET_SIZE + int'(s1_q.col_slot));
  assign tab_wr_ok = (int'(s1_q.row_slot) < ALPHABET_SIZE) &&
                     (int'(s1_q.col_slot) < ALPHABET_SIZE);

  assign step_d.count = !both_gap && known;
  assign step_d.err   = !both_gap && !known;
  assign step_d.last  = s1_q.last_pair;

  assign s2_free    = !s2_v_q || step_ready;
  assign s1_fire    = s1_v_q && s2_free;
  assign in_ready_o = !s1_v_q || s2_free;

  // distance table, one access per cycle
  always_ff @(posedge clk_i) begin
    if (s1_fire && (s1_q.command == CmdTabWr) && tab_wr_ok) begin
      tab_mem[wr_idx] <= s1_q.entry_value;
    end
    if (s1_fire && s1_cmp && step_d.count) begin
      td_q <= tab_mem[rd_idx];
    end
    if (s1_fire) begin
      s2_step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q    <= 1'b0;
      s2_v_q    <= 1'b0;
      map_vld_q <= '0;
    end else begin
      if (in_ready_o) begin
        s1_v_q <= in_valid_i;
      end
      if (s2_free) begin
        s2_v_q <= s1_fire && s1_cmp;
      end
      if (in_fire && (in_data_i.command == CmdMapWr)) begin
        map_vld_q[in_data_i.first_char] <= 1'b1;
      end
    end
  end

  gsd_accum #(
    .SUM_WIDTH(SUM_WIDTH)
  ) u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_valid_i(s2_v_q),
    .step_ready_o(step_ready),
    .step_i      (s2_step_q),
    .entry_i     (td_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  a_step_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_v_q |-> !(s2_step_q.count && s2_step_q.err))
    else $error("pair both counted and flagged unknown");

  a_write_no_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && !s1_cmp |=> !s2_v_q)
    else $error("write beat reached the accumulate stage");

  a_map_valid_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (in_data_i.command == CmdMapWr) |=> map_vld_q[$past(in_data_i.first_char)])
    else $error("symbol map entry not marked after write");

endmodule

// ===== test/gapped_sequence_distance_top_tb.sv =====
module gapped_sequence_distance_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gsd_pkg::*;

  localparam logic [1:0]  CmdUnused = 2'd3;
  localparam logic [63:0] SumMax    = 64'hFFFF_FFFF;
  localparam int          HoldBeats = 300;

  // directed rows: beat fields, then an optional hand-typed result
  typedef struct packed {
    logic [1:0]         cmd;
    logic [7:0]         a;
    logic [7:0]         b;
    logic               last;
    logic [4:0]         rs;
    logic [4:0]         cs;
    logic               rk;
    logic               ck;
    logic signed [15:0] ev;
    logic               chk;
    logic [31:0]        want_dist;
    logic [15:0]        runs;
    logic               unk;
  } dir_row_t;

  localparam dir_row_t DirPlan [24] = '{
    //   cmd         a        b        lst rs  cs rk ck entry        chk dist   runs unk
    '{CmdTabWr,   "A",     "A",     0,  0,  0, 0, 0, 0,           0,  0,     0,   0},
    '{CmdCompare, "A",     "B",     1,  0,  0, 0, 0, 0,           1,  0,     0,   1},
    '{CmdCompare, GapDot,  GapDash, 1,  0,  0, 0, 0, 0,           1,  0,     0,   0},
    '{CmdMapWr,   "A",     "A",     0,  0,  0, 1, 1, 0,           0,  0,     0,   0},
    '{CmdMapWr,   "B",     "A",     0,  31, 31, 1, 1, 0,          0,  0,     0,   0},
    '{CmdTabWr,   "A",     "A",     0,  31, 31, 0, 0, 16'sh7FFF,  0,  0,     0,   0},
    '{CmdTabWr,   "A",     "A",     0,  0,  31, 0, 0, GapEntry,   0,  0,     0,   0},
    '{CmdTabWr,   "A",     "A",     0,  31, 0, 0, 0, 16'sh8000,   0,  0,     0,   0},
    '{CmdCompare, "B",     "B",     1,  0,  0, 0, 0, 0,           1,  32767, 0,   0},
    '{CmdCompare, "A",     "B",     0,  0,  0, 0, 0, 0,           0,  0,     0,   0},
    '{CmdCompare, "A",     "B",     0,  0,  0, 0, 0, 0,           0,  0,     0,   0},
    '{CmdCompare, "B",     "A",     0,  0,  0, 0, 0, 0,           0,  0,     0,   0},
    '{CmdCompare, "A",     "B",     1,  0,  0, 0, 0, 0,           1,  512,   2,   0},
    '{CmdUnused,  "A",     "B",     1,  31, 31, 1, 1, 16'sh7FFF,  0,  0,     0,   0},
    '{CmdMapWr,   "C",     "A",     0,  5,  0, 0, 1, 0,           0,  0,     0,   0},
    '{CmdTabWr,   "A",     "A",     0,  5,  0, 0, 0, 100,         0,  0,     0,   0},
    '{CmdCompare, "C",     "A",     1,  0,  0, 0, 0, 0,           1,  0,     0,   1},
    '{CmdTabWr,   "A",     "A",     1,  0,  0, 0, 0, 256,         0,  0,     0,   0},
    '{CmdCompare, "A",     "A",     0,  0,  0, 0, 0, 0,           0,  0,     0,   0},
    '{CmdCompare, GapDash, "A",     0,  0,  0, 0, 0, 0,           0,  0,     0,   0},
    '{CmdCompare, "A",     GapDot,  1,  0,  0, 0, 0, 0,           1,  256,   0,   1},
    '{CmdMapWr,   GapDot,  "A",     0,  0,  31, 1, 1, 0,          0,  0,     0,   0},
    '{CmdCompare, GapDot,  GapDot,  0,  0,  0, 0, 0, 0,           0,  0,     0,   0},
    '{CmdCompare, "A",     GapDot,  1,  0,  0, 0, 0, 0,           1,  256,   1,   0}
  };

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  gsd_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  gsd_out_t out_data;

  // shadow of the block: symbol map, distance table, accumulators
  bit                 map_row_ok   [256];
  bit                 map_col_ok   [256];
  bit [4:0]           map_row      [256];
  bit [4:0]           map_col      [256];
  bit [4:0]           map_row_slot [256];
  bit [4:0]           map_col_slot [256];
  logic signed [15:0] dist_tab     [1024];
  bit                 tab_loaded   [1024];
  logic [63:0]        acc_sum      = '0;
  logic [15:0]        acc_runs     = '0;
  bit                 acc_prev_gap = 1'b0;
  bit                 acc_err      = 1'b0;
  gsd_out_t           pending_distances [$];

  int mismatch_count = 0;
  int beats_sent     = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_left      = 0;
  bit hold_req       = 1'b0;

  gapped_sequence_distance_top u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  always #5ns clk = ~clk;

  initial begin
    #20ms;
    $display("** gapped_sequence_distance_top: FAILED **");
    $finish;
  end

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("%0t mismatch: %s", $time, what);
  endtask

  function automatic gsd_in_t random_beat();
    logic [63:0] bits;
    bits = {$urandom, $urandom};
    return bits[$bits(gsd_in_t)-1:0];
  endfunction

  function automatic logic signed [15:0] pick_entry();
    case ($urandom_range(0, 9))
      0, 1, 2: return GapEntry;
      3, 4:    return 16'($urandom_range(1, 1000));
      5:       return '0;
      6: begin
        case ($urandom_range(0, 4))
          0:       return 16'sh7FFF;
          1:       return 16'sh8000;
          2:       return -16'sd255;
          3:       return -16'sd257;
          default: return 16'sd1;
        endcase
      end
      7:       return -16'($urandom_range(1, 1000));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pool_char();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 8) return GapDot;
    if (p < 16) return GapDash;
    if (p < 21) return 8'($urandom);
    return 8'(8'h41 + $urandom_range(0, 11));
  endfunction

  task automatic accumulate_beat(input gsd_in_t beat);
    logic signed [15:0] v;
    logic [63:0]        total;
    gsd_out_t           predicted;
    case (beat.command)
      CmdMapWr: begin
        map_row_ok[beat.first_char]   = beat.row_known;
        map_col_ok[beat.first_char]   = beat.col_known;
        map_row[beat.first_char]      = beat.row_known ? beat.row_slot : 5'd0;
        map_col[beat.first_char]      = beat.col_known ? beat.col_slot : 5'd0;
        map_row_slot[beat.first_char] = beat.row_slot;
        map_col_slot[beat.first_char] = beat.col_slot;
      end
      CmdTabWr: begin
        dist_tab[{beat.row_slot, beat.col_slot}]   = beat.entry_value;
        tab_loaded[{beat.row_slot, beat.col_slot}] = 1'b1;
      end
      CmdCompare: begin
        if (!((beat.first_char == GapDot || beat.first_char == GapDash) &&
              (beat.second_char == GapDot || beat.second_char == GapDash))) begin
          if (!map_row_ok[beat.first_char] || !map_col_ok[beat.second_char]) begin
            acc_err = 1'b1;
          end else begin
            v = dist_tab[{map_row[beat.first_char], map_col[beat.second_char]}];
            if (v > 0) begin
              acc_sum = acc_sum + 64'(v);
              if (acc_sum > SumMax) acc_sum = SumMax;
            end else if (v == GapEntry && !acc_prev_gap && acc_runs != 16'hFFFF) begin
              acc_runs++;
            end
            acc_prev_gap = (v == GapEntry);
          end
        end
        if (beat.last_pair) begin
          total = acc_sum + 64'(acc_runs) * 64'd256;
          if (total > SumMax) total = SumMax;
          predicted.distance     = total[31:0];
          predicted.indel_count  = acc_runs;
          predicted.unknown_char = acc_err;
          pending_distances.insert(pending_distances.size(), predicted);
          acc_sum      = '0;
          acc_runs     = '0;
          acc_prev_gap = 1'b0;
          acc_err      = 1'b0;
        end
      end
      default: ;
    endcase
  endtask

  // called at a rising edge; returns at the edge where the beat is taken
  task automatic drive_beat(input gsd_in_t beat);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (!in_ready);
    accumulate_beat(beat);
    if (beat.command != CmdUnused) beats_sent++;
  endtask

  task automatic load_symbol(input logic [7:0] sym, input logic [4:0] rs, input logic [4:0] cs,
                             input logic rk, input logic ck);
    gsd_in_t beat;
    beat = random_beat();
    beat.command    = CmdMapWr;
    beat.first_char = sym;
    beat.row_slot   = rs;
    beat.col_slot   = cs;
    beat.row_known  = rk;
    beat.col_known  = ck;
    drive_beat(beat);
  endtask

  task automatic load_entry(input logic [4:0] rs, input logic [4:0] cs,
                            input logic signed [15:0] ev);
    gsd_in_t beat;
    beat = random_beat();
    beat.command     = CmdTabWr;
    beat.row_slot    = rs;
    beat.col_slot    = cs;
    beat.entry_value = ev;
    drive_beat(beat);
  endtask

  // any table cell the pair could touch gets loaded first
  task automatic send_pair(input logic [7:0] a, input logic [7:0] b, input logic last);
    logic [4:0] rows [2];
    logic [4:0] cols [2];
    gsd_in_t    beat;
    rows[0] = map_row[a];
    rows[1] = map_row_slot[a];
    cols[0] = map_col[b];
    cols[1] = map_col_slot[b];
    for (int i = 0; i < 2; i++) begin
      for (int j = 0; j < 2; j++) begin
        if (!tab_loaded[{rows[i], cols[j]}]) load_entry(rows[i], cols[j], pick_entry());
      end
    end
    beat = random_beat();
    beat.command     = CmdCompare;
    beat.first_char  = a;
    beat.second_char = b;
    beat.last_pair   = last;
    drive_beat(beat);
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct, input int n_beats,
                           input bit squeeze);
    int          target;
    int          len;
    int unsigned pick;
    gsd_in_t     beat;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    if (squeeze) hold_req = 1'b1;
    target = beats_sent + n_beats;
    while (beats_sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        load_symbol(pool_char(), 5'($urandom), 5'($urandom), $urandom_range(0, 9) != 0,
                    $urandom_range(0, 9) != 0);
      end else if (pick < 14) begin
        load_entry(5'($urandom), 5'($urandom), pick_entry());
      end else if (pick < 17) begin
        beat = random_beat();
        beat.command = CmdUnused;
        drive_beat(beat);
      end else begin
        len = $urandom_range(1, 10);
        for (int k = 0; k < len; k++) begin
          send_pair(pool_char(), pool_char(), k == len - 1 && $urandom_range(0, 19) != 0);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HoldBeats;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin : check_results
    gsd_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_distances.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected: %h", out_data));
      end else begin
        want = pending_distances.pop_front();
        if (out_data.distance !== want.distance || out_data.indel_count !== want.indel_count ||
            out_data.unknown_char !== want.unknown_char) begin
          report_mismatch($sformatf("distance %h/%h indels %h/%h unknown %b/%b (got/exp)",
                                    out_data.distance, want.distance, out_data.indel_count,
                                    want.indel_count, out_data.unknown_char, want.unknown_char));
        end
      end
    end
  end

  initial begin
    int drain;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < $size(DirPlan); i++) begin
      drive_beat({DirPlan[i].cmd, DirPlan[i].a, DirPlan[i].b, DirPlan[i].last, DirPlan[i].rs,
                  DirPlan[i].cs, DirPlan[i].rk, DirPlan[i].ck, DirPlan[i].ev});
      if (DirPlan[i].chk && pending_distances.size() != 0) begin
        pending_distances[pending_distances.size() - 1] =
          {DirPlan[i].want_dist, DirPlan[i].runs, DirPlan[i].unk};
      end
    end

    // one longer sequence alternating gap runs with the largest positive entry
    load_symbol("G", 5'd1, 5'd1, 1'b1, 1'b1);
    load_symbol("P", 5'd2, 5'd2, 1'b1, 1'b1);
    load_entry(5'd1, 5'd1, GapEntry);
    load_entry(5'd2, 5'd2, 16'sh7FFF);
    for (int k = 0; k < 30; k++) begin
      send_pair("G", "G", 1'b0);
      send_pair("P", "P", k == 29);
    end

    for (int k = 0; k < 12; k++) begin
      load_symbol(8'(8'h41 + k), 5'($urandom), 5'($urandom), 1'b1, 1'b1);
    end
    load_symbol(GapDot, 5'($urandom), 5'($urandom), 1'b1, 1'b1);
    load_symbol(GapDash, 5'($urandom), 5'($urandom), 1'b1, 1'b1);

    run_phase(0, 0, 200, 1'b1);
    run_phase(71, 0, 200, 1'b0);
    run_phase(0, 71, 200, 1'b1);
    run_phase(31, 31, 200, 1'b0);

    in_valid <= 1'b0;
    drain = 0;
    while (pending_distances.size() != 0 && drain < 20000) begin
      @(posedge clk);
      drain++;
    end
    repeat (8) @(posedge clk);
    if (pending_distances.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", pending_distances.size()));
    end

    if (mismatch_count == 0) begin
      $display("** gapped_sequence_distance_top: PASSED **");
    end else begin
      $display("** gapped_sequence_distance_top: FAILED **");
    end
    $finish;
  end

endmodule
